// ===== design/gwsl_pkg.sv =====
// ----------------------------------------------------------------------------
// gwsl_pkg
// Shared types and constants of the gain and soft limiter datapath.
// ----------------------------------------------------------------------------
package gwsl_pkg;

	localparam int SAMPLE_W = 32;
	localparam int SLOPE_W  = 16;
	localparam int THRESH_W = 31;
	localparam int PROD_W   = 64;
	localparam int COUNT_W  = 48;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_BITS = 16;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIM_EN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

	// full scale in Q.16 on the product width
	localparam logic signed [PROD_W-1:0] FULL_Q = 64'sh0000_7FFF_FFFF_0000;
	localparam logic signed [PROD_W-1:0] MIN_Q  = 64'shFFFF_8000_0000_0000;
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = 64'sh0000_0000_0000_FFFF;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [2:0] {
		PATH_PLAIN = 3'b001,
		PATH_UPPER = 3'b010,
		PATH_LOWER = 3'b100
	} path_t;

	typedef struct packed {
		path_t path;
		logic  lim_en;
	} ctl_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] gain;
		logic                       lim_en;
		logic [SLOPE_W-1:0]         slope;
		logic [THRESH_W-1:0]        threshold;
	} cfg_t;

endpackage

// ===== design/gwsl_in_if.sv =====
// ----------------------------------------------------------------------------
// gwsl_in_if
// Input sample channel: valid/ready handshake with one signed sample.
// ----------------------------------------------------------------------------
interface gwsl_in_if
	import gwsl_pkg::*;
	();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== design/gwsl_out_if.sv =====
// ----------------------------------------------------------------------------
// gwsl_out_if
// Result channel: valid/ready handshake with the sample and its flags.
// ----------------------------------------------------------------------------
interface gwsl_out_if
	import gwsl_pkg::*;
	();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       was_limited;
	logic                       was_clipped;

	modport source (output valid, output sample_out, output was_limited,
		output was_clipped, input ready);
	modport sink   (input valid, input sample_out, input was_limited,
		input was_clipped, output ready);
endinterface

// ===== design/gwsl_front.sv =====
// ----------------------------------------------------------------------------
// gwsl_front
// Stage 1: threshold compare, path choice and multiplier operand selection.
// ----------------------------------------------------------------------------
module gwsl_front
	import gwsl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       in_valid,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  cfg_t                       cfg,
	output logic                       valid_s1,
	output ctl_t                       ctl_s1,
	output logic signed [SAMPLE_W-1:0] opa_s1,
	output logic signed [SAMPLE_W-1:0] opb_s1
);

	logic signed [SAMPLE_W-1:0] thr_pos;
	logic signed [SAMPLE_W-1:0] thr_neg;
	logic signed [SAMPLE_W:0]   dist_hi;
	logic signed [SAMPLE_W:0]   dist_lo;
	logic                       above;
	logic                       below;
	ctl_t                       ctl_c;
	logic signed [SAMPLE_W-1:0] opa_c;
	logic signed [SAMPLE_W-1:0] opb_c;

	assign thr_pos = $signed({1'b0, cfg.threshold});
	assign thr_neg = -thr_pos;
	assign above   = sample > thr_pos;
	assign below   = sample < thr_neg;
	// both distances fit 32 signed bits on the paths that use them
	assign dist_hi = $signed({SAMPLE_MAX[SAMPLE_W-1], SAMPLE_MAX}) -
		$signed({sample[SAMPLE_W-1], sample});
	assign dist_lo = $signed({SAMPLE_MAX[SAMPLE_W-1], SAMPLE_MAX}) +
		$signed({sample[SAMPLE_W-1], sample});

	always_comb begin
		ctl_c.lim_en = cfg.lim_en;
		ctl_c.path   = PATH_PLAIN;
		opa_c        = cfg.gain;
		opb_c        = sample;
		if (cfg.lim_en && above) begin
			ctl_c.path = PATH_UPPER;
			opa_c      = $signed({{(SAMPLE_W-SLOPE_W){1'b0}}, cfg.slope});
			opb_c      = dist_hi[SAMPLE_W-1:0];
		end else if (cfg.lim_en && below) begin
			ctl_c.path = PATH_LOWER;
			opa_c      = $signed({{(SAMPLE_W-SLOPE_W){1'b0}}, cfg.slope});
			opb_c      = dist_lo[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s1 <= ctl_c;
			opa_s1 <= opa_c;
			opb_s1 <= opb_c;
		end
	end

endmodule

// ===== design/gwsl_mult.sv =====
// ----------------------------------------------------------------------------
// gwsl_mult
// Stage 2: shared signed 32x32 multiplier for gain and limiter slope.
// ----------------------------------------------------------------------------
module gwsl_mult
	import gwsl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       valid_s1,
	input  ctl_t                       ctl_s1,
	input  logic signed [SAMPLE_W-1:0] opa_s1,
	input  logic signed [SAMPLE_W-1:0] opb_s1,
	output logic                       valid_s2,
	output ctl_t                       ctl_s2,
	output logic signed [PROD_W-1:0]   prod_s2
);

	logic signed [PROD_W-1:0] prod_c;

	assign prod_c = PROD_W'(opa_s1) * PROD_W'(opb_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s2  <= ctl_s1;
			prod_s2 <= prod_c;
		end
	end

endmodule

// ===== design/gwsl_post.sv =====
// ----------------------------------------------------------------------------
// gwsl_post
// Stages 3 and 4: saturation, truncation toward zero, limiter mapping,
// result register and the saturating event counters.
// ----------------------------------------------------------------------------
module gwsl_post
	import gwsl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load3,
	input  logic                       load4,
	input  logic                       valid_s2,
	input  ctl_t                       ctl_s2,
	input  logic signed [PROD_W-1:0]   prod_s2,
	output logic                       valid_s3,
	output logic                       valid_s4,
	output logic signed [SAMPLE_W-1:0] res_s4,
	output logic                       lim_s4,
	output logic                       clip_s4
);

	ctl_t                       ctl_s3;
	logic signed [PROD_W-1:0]   val_s3;
	logic                       hi_s3;
	logic                       lo_s3;
	logic signed [PROD_W-1:0]   val_c;
	logic                       hi_c;
	logic                       lo_c;
	logic signed [SAMPLE_W-1:0] res_c;
	logic signed [SAMPLE_W-1:0] shifted;
	logic                       lim_c;
	logic                       clip_c;
	logic                       len_s4;
	logic [COUNT_W-1:0]         limited_cnt_q;
	logic [COUNT_W-1:0]         total_cnt_q;
	logic [COUNT_W-1:0]         clip_cnt_q;

	// stage 3: bias negative products for truncation, or distance from full scale
	always_comb begin
		hi_c = 1'b0;
		lo_c = 1'b0;
		case (ctl_s2.path)
			PATH_PLAIN: begin
				hi_c  = prod_s2 > FULL_Q;
				lo_c  = prod_s2 < MIN_Q;
				val_c = prod_s2[PROD_W-1] ? prod_s2 + ROUND_BIAS : prod_s2;
			end
			default: begin
				val_c = FULL_Q - prod_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load3) begin
			ctl_s3 <= ctl_s2;
			val_s3 <= val_c;
			hi_s3  <= hi_c;
			lo_s3  <= lo_c;
		end
	end

	// stage 4: shift down and map; the lower limiter never reaches the min clamp
	assign shifted = val_s3[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];

	always_comb begin
		case (ctl_s3.path)
			PATH_PLAIN: begin
				if (hi_s3) begin
					res_c = SAMPLE_MAX;
				end else if (lo_s3) begin
					res_c = SAMPLE_MIN;
				end else begin
					res_c = shifted;
				end
			end
			PATH_LOWER: res_c = -shifted;
			default:    res_c = shifted;
		endcase
	end

	assign lim_c  = ctl_s3.path != PATH_PLAIN;
	assign clip_c = hi_s3 || lo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (load4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load4) begin
			res_s4  <= res_c;
			lim_s4  <= lim_c;
			clip_s4 <= clip_c;
			len_s4  <= ctl_s3.lim_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limited_cnt_q <= '0;
			total_cnt_q   <= '0;
			clip_cnt_q    <= '0;
		end else if (load4 && valid_s3) begin
			if (ctl_s3.lim_en && total_cnt_q != COUNT_MAX) begin
				total_cnt_q <= total_cnt_q + 1'b1;
			end
			if (lim_c && limited_cnt_q != COUNT_MAX) begin
				limited_cnt_q <= limited_cnt_q + 1'b1;
			end
			if (clip_c && clip_cnt_q != COUNT_MAX) begin
				clip_cnt_q <= clip_cnt_q + 1'b1;
			end
		end
	end

	a_lim_clip_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> !(lim_s4 && clip_s4))
		else $error("limited result also flagged as clipped");

	a_lim_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && lim_s4) |-> len_s4)
		else $error("limiter mapping applied while limiter disabled");

	a_lim_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		limited_cnt_q <= total_cnt_q)
		else $error("limited count ahead of total count");

	a_clip_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		clip_cnt_q >= $past(clip_cnt_q))
		else $error("clip count went backwards");

endmodule

// ===== design/gain_with_soft_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// gain_with_soft_limiter_unit
// Volume gain with optional soft peak limiter on a 32-bit sample stream.
// ----------------------------------------------------------------------------
// The unit takes one sample per cycle when the output is not stalled and
// passes it through the stages in order: stage 1 picks the path and the
// multiplier operands, stage 2 is the shared 32x32 multiplier, stage 3
// saturates or forms the distance from full scale, and stage 4 is the
// output register. Each stage holds its item while the next one is full,
// so a stall on the result side back-pressures the input without loss.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// and should only change while no sample is in flight.
module gain_with_soft_limiter_unit
	import gwsl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]  cfg_wdata,
	gwsl_in_if.sink              in_ch,
	gwsl_out_if.source           out_ch
);

	cfg_t                       cfg_q;
	logic                       rdy1;
	logic                       rdy2;
	logic                       rdy3;
	logic                       rdy4;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       valid_s3;
	logic                       valid_s4;
	ctl_t                       ctl_s1;
	ctl_t                       ctl_s2;
	logic signed [SAMPLE_W-1:0] opa_s1;
	logic signed [SAMPLE_W-1:0] opb_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [SAMPLE_W-1:0] res_s4;
	logic                       lim_s4;
	logic                       clip_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain      <= 32'sh0001_0000;
			cfg_q.lim_en    <= 1'b0;
			cfg_q.slope     <= '0;
			cfg_q.threshold <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN:      cfg_q.gain      <= $signed(cfg_wdata);
				REG_LIM_EN:    cfg_q.lim_en    <= cfg_wdata[0];
				REG_SLOPE:     cfg_q.slope     <= cfg_wdata[SLOPE_W-1:0];
				REG_THRESHOLD: cfg_q.threshold <= cfg_wdata[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its content moves on
	assign rdy4 = !valid_s4 || out_ch.ready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign in_ch.ready = rdy1;

	gwsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (rdy1),
		.in_valid (in_ch.valid),
		.sample   (in_ch.sample_in),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.opa_s1   (opa_s1),
		.opb_s1   (opb_s1)
	);

	gwsl_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (rdy2),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.opa_s1   (opa_s1),
		.opb_s1   (opb_s1),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.prod_s2  (prod_s2)
	);

	gwsl_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.load3    (rdy3),
		.load4    (rdy4),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.prod_s2  (prod_s2),
		.valid_s3 (valid_s3),
		.valid_s4 (valid_s4),
		.res_s4   (res_s4),
		.lim_s4   (lim_s4),
		.clip_s4  (clip_s4)
	);

	assign out_ch.valid       = valid_s4;
	assign out_ch.sample_out  = res_s4;
	assign out_ch.was_limited = lim_s4;
	assign out_ch.was_clipped = clip_s4;

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s4 |-> in_ch.ready)
		else $error("input stalled while the output register is empty");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gain and soft limiter unit. Samples go in over
// the input channel with random gaps while the result side stalls at random.
// Each accepted sample is scored against an in-bench model of the plain gain,
// upper and lower limiter paths and saturation, and every result transfer is
// checked field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb
	import gwsl_pkg::*;
();

	localparam longint S_MAX      = 64'sd2147483647;
	localparam longint S_MIN      = -64'sd2147483648;
	localparam longint FULL_SCALE = S_MAX * 65536;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     PHASE_ITEMS    = 50;
	localparam int     PHASES         = 9;

	typedef struct {
		logic signed [SAMPLE_W-1:0] stim;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       lim;
		logic                       clip;
	} scaled_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SAMPLE_W-1:0]  cfg_wdata;

	gwsl_in_if  in_ch ();
	gwsl_out_if out_ch ();

	gain_with_soft_limiter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// shadow of the register file and the counters
	longint      gain_q;
	bit          lim_en_q;
	longint      slope_q;
	longint      thresh_q;
	logic [47:0] limited_cnt;
	logic [47:0] total_cnt;
	logic [47:0] clipped_cnt;

	scaled_t scaled_q[$];
	int      mismatches;
	bit      no_idle;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic scaled_t scale_sample(input logic signed [SAMPLE_W-1:0] s);
		longint  sv;
		longint  prod;
		longint  r;
		scaled_t o;
		sv     = s;
		o.stim = s;
		o.lim  = 1'b0;
		o.clip = 1'b0;
		if (lim_en_q && total_cnt != '1)
			total_cnt = total_cnt + 1;
		if (lim_en_q && sv > thresh_q) begin
			r     = (FULL_SCALE - slope_q * (S_MAX - sv)) / 65536;
			o.lim = 1'b1;
		end else if (lim_en_q && sv < -thresh_q) begin
			// distance from full scale on the negative side, mirrored
			r = -((FULL_SCALE - slope_q * (S_MAX + sv)) / 65536);
			if (r < S_MIN)
				r = S_MIN;
			o.lim = 1'b1;
		end else begin
			prod = gain_q * sv;
			if (prod > FULL_SCALE) begin
				r      = S_MAX;
				o.clip = 1'b1;
			end else if (prod < S_MIN * 65536) begin
				r      = S_MIN;
				o.clip = 1'b1;
			end else begin
				r = prod / 65536;
			end
		end
		if (o.lim && limited_cnt != '1)
			limited_cnt = limited_cnt + 1;
		if (o.clip && clipped_cnt != '1)
			clipped_cnt = clipped_cnt + 1;
		o.sample = r[31:0];
		return o;
	endfunction

	task automatic report_mismatch(input string what, input scaled_t want, input longint got,
			input longint exp_val);
		$display("tb: mismatch %s for sample %0d: got %0d expected %0d",
			what, want.stim, got, exp_val);
		mismatches++;
	endtask

	// result side: score each transfer, watchdog on cycles with no transfer
	always @(posedge clk) begin : score_results
		scaled_t want;
		int      stuck;
		if (out_ch.valid && out_ch.ready) begin
			if (scaled_q.size() == 0) begin
				want      = '{default: '0};
				want.stim = 'x;
				report_mismatch("unexpected result", want, longint'(out_ch.sample_out), 0);
			end else begin
				want = scaled_q.pop_front();
				if (out_ch.sample_out !== want.sample)
					report_mismatch("sample_out", want, longint'(out_ch.sample_out),
						longint'(want.sample));
				if (out_ch.was_limited !== want.lim)
					report_mismatch("was_limited", want, longint'(out_ch.was_limited),
						longint'(want.lim));
				if (out_ch.was_clipped !== want.clip)
					report_mismatch("was_clipped", want, longint'(out_ch.was_clipped),
						longint'(want.clip));
			end
		end
		if (!arst_n || (out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
			stuck = 0;
		else
			stuck++;
		if (stuck >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side back-pressure in random bursts
	initial begin : result_ready
		int stall_left;
		stall_left   = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (no_idle) begin
				out_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 6) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 5);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		if (!no_idle && $urandom_range(0, 6) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		scaled_q.push_back(scale_sample(s));
	endtask

	// wait until every expected result has been taken
	task automatic drain;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (scaled_q.size() != 0)
			@(posedge clk);
	endtask

	// unused upper bits of the write data carry junk, the unit must mask them
	task automatic set_config(input logic signed [SAMPLE_W-1:0] g, input bit en,
			input logic [SLOPE_W-1:0] sl, input logic [THRESH_W-1:0] th);
		logic [31:0] junk;
		junk      = $urandom;
		cfg_we    <= 1'b1;
		cfg_index <= REG_GAIN;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_index <= REG_LIM_EN;
		cfg_wdata <= {junk[31:1], en};
		@(posedge clk);
		cfg_index <= REG_SLOPE;
		cfg_wdata <= {junk[15:0], sl};
		@(posedge clk);
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= {junk[31], th};
		@(posedge clk);
		cfg_we   <= 1'b0;
		gain_q   = longint'(g);
		lim_en_q = en;
		slope_q  = longint'(sl);
		thresh_q = longint'(th);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
		if (v > S_MAX)
			v = S_MAX;
		if (v < S_MIN)
			v = S_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample;
		longint delta;
		delta = longint'($urandom_range(0, 64)) - 32;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return clamp_sample(longint'($urandom_range(0, 4000)) - 2000);
			2: return clamp_sample(thresh_q + delta);
			3: return clamp_sample(-thresh_q + delta);
			4: begin
				case ($urandom_range(0, 4))
					0: return SAMPLE_MAX;
					1: return SAMPLE_MIN;
					2: return 32'sd1;
					3: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h7FFF_FFFF)
				: -$urandom_range(0, 32'h7FFF_FFFF);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_gain;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return SAMPLE_W'(longint'($urandom_range(0, 32'h80000)) - 32'h40000);
			2: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			default: return SAMPLE_W'(longint'($urandom_range(0, 32'h20000)) - 32'h10000);
		endcase
	endfunction

	// reset values: unity gain, limiter off
	task automatic test_reset_defaults;
		send_sample(32'sd0);
		send_sample(32'sd1);
		send_sample(-32'sd1);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		drain();
	endtask

	task automatic test_gain_extremes;
		set_config(SAMPLE_MIN, 1'b0, 16'h1234, 31'd0);
		send_sample(32'sd1);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		drain();
		set_config(SAMPLE_MAX, 1'b0, 16'd0, 31'h7FFF_FFFF);
		send_sample(SAMPLE_MAX);
		send_sample(-32'sd3);
		drain();
		// -1.5 times one truncates toward zero
		set_config(-32'sh18000, 1'b0, 16'd0, 31'h7FFF_FFFF);
		send_sample(32'sd1);
		send_sample(-32'sd1);
		drain();
		// gain of two lands exactly on the lower rail without clipping
		set_config(32'sh20000, 1'b0, 16'd0, 31'h7FFF_FFFF);
		send_sample(-32'sh4000_0000);
		send_sample(32'sh4000_0000);
		drain();
	endtask

	task automatic test_limiter_paths;
		set_config(32'sh18000, 1'b1, 16'h8000, 31'h4000_0000);
		send_sample(SAMPLE_MAX);
		send_sample(32'sh4000_0001);
		send_sample(32'sh4000_0000);
		send_sample(-32'sh4000_0000);
		send_sample(-32'sh4000_0001);
		send_sample(SAMPLE_MIN);
		drain();
		// zero slope pins the limited samples to plus and minus full scale
		set_config(32'sh10000, 1'b1, 16'd0, 31'd0);
		send_sample(32'sd1);
		send_sample(-32'sd1);
		send_sample(32'sd0);
		drain();
		set_config(32'sh10000, 1'b1, 16'hFFFF, 31'd0);
		send_sample(SAMPLE_MIN);
		send_sample(32'sd1);
		drain();
	endtask

	task automatic test_random_stream;
		logic signed [SAMPLE_W-1:0] g;
		bit                         en;
		logic [SLOPE_W-1:0]         sl;
		logic [THRESH_W-1:0]        th;
		for (int p = 0; p < PHASES; p++) begin
			g  = pick_gain();
			en = $urandom_range(0, 3) != 0;
			sl = $urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? 16'hFFFF : 16'd0)
				: 16'($urandom);
			th = $urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0)
				: 31'($urandom);
			if (p == 0) begin
				g  = SAMPLE_MAX;
				en = 1'b1;
				sl = 16'hFFFF;
				th = 31'h7FFF_FFFF;
			end else if (p == 1) begin
				g  = SAMPLE_MIN;
				en = 1'b1;
				sl = 16'd0;
				th = 31'd0;
			end else if (p == 2) begin
				en = 1'b0;
			end
			no_idle = (p == PHASES - 1);
			set_config(g, en, sl, th);
			repeat (PHASE_ITEMS)
				send_sample(pick_sample());
			drain();
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_GAIN;
		cfg_wdata       <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.sample_in <= '0;
		no_idle     = 1'b0;
		mismatches  = 0;
		gain_q      = 65536;
		lim_en_q    = 1'b0;
		slope_q     = 0;
		thresh_q    = S_MAX;
		limited_cnt = '0;
		total_cnt   = '0;
		clipped_cnt = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_gain_extremes();
		test_limiter_paths();
		test_random_stream();

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== gain_with_soft_limiter_unit.f =====
design/gwsl_pkg.sv
design/gwsl_in_if.sv
design/gwsl_out_if.sv
design/gwsl_front.sv
design/gwsl_mult.sv
design/gwsl_post.sv
design/gain_with_soft_limiter_unit.sv
dv/tb.sv
